// ===== sv/vau_pkg.sv =====
// shared types, widths and step functions for the vector arithmetic unit
package vau_pkg;

    // component and fraction widths
    localparam int CW  = 24;
    localparam int FB  = 16;
    localparam int SW  = 40;
    // product, sum of squares and square root widths
    localparam int PW  = 2 * CW;
    localparam int SQW = 2 * CW;
    localparam int RW  = CW;
    // quotient bits and divider remainder width
    localparam int QW  = FB + 2;
    localparam int DVW = RW + QW;
    // pipeline depths, two steps per stage
    localparam int NSQ = RW / 2;
    localparam int NDV = QW / 2;

    typedef enum logic [1:0] {
        CMD_CROSS = 2'd0,
        CMD_DOT   = 2'd1,
        CMD_LEN   = 2'd2,
        CMD_NORM  = 2'd3
    } t_cmd;

    // item state after the multiply stages
    typedef struct packed {
        t_cmd                   cmd;
        logic [2:0][CW-1:0]     r;
        logic [SW-1:0]          scalar;
        logic                   sat;
        logic [2:0][CW-1:0]     mag;
        logic [2:0]             neg;
        logic [SQW-1:0]         sumsq;
    } t_mid;

    // square root working state
    typedef struct packed {
        logic [SQW-1:0] rem;
        logic [RW-1:0]  root;
    } t_sqs;

    typedef struct packed {
        t_mid mid;
        t_sqs s;
    } t_sq;

    // divider state, one lane per component
    typedef struct packed {
        t_mid                mid;
        logic [RW-1:0]       root;
        logic [2:0][DVW-1:0] rem;
        logic [2:0][QW-1:0]  q;
    } t_dv;

    // one digit of the square root: try setting root bit b
    function automatic t_sqs sqrt_step(input t_sqs s, input int b);
        t_sqs       o;
        logic [SQW:0] trial;
        o = s;
        trial = ({1'b0, SQW'(s.root)} << (b + 1)) | ((SQW + 1)'(1) << (2 * b));
        if ({1'b0, s.rem} >= trial) begin
            o.rem  = s.rem - trial[SQW-1:0];
            o.root = s.root | (RW'(1) << b);
        end
        return o;
    endfunction

    // one restoring division step for quotient bit k
    function automatic logic [DVW+QW-1:0] div_step(input logic [DVW-1:0] rem,
                                                   input logic [QW-1:0] q,
                                                   input logic [RW-1:0] len,
                                                   input int k);
        logic [DVW-1:0] t;
        logic [DVW-1:0] nr;
        logic [QW-1:0]  nq;
        t  = DVW'(len) << k;
        nr = rem;
        nq = q;
        if (rem >= t) begin
            nr = rem - t;
            nq = q | (QW'(1) << k);
        end
        return {nr, nq};
    endfunction

endpackage

// ===== sv/vector3_arith_unit.sv =====
// vector unit top level: cross, dot, length and normalize of Q8.16 3-vectors
//
//   channel   | dir | tdata (low bit first)              | tuser
//   s_axis    | in  | a_x a_y a_z b_x b_y b_z (144 bits) | cmd
//   m_axis    | out | r_x r_y r_z scalar (112 bits)      | zero_length saturated
//
// one item per cycle unless m_axis stalls; each item reaches the output register
// through two multiply, twelve square-root and nine divider stages and one output.
// latency is set by the square root (two bits per stage) and divider chains.
// reset clears the valid bits only; a stall on m_axis freezes the whole pipeline,
// and s_axis is ready whenever the output register is empty or being taken.
module vector3_arith_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [143:0]  i_s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
    input  logic [1:0]    i_s_axis_tuser,   // cmd
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [111:0]  o_m_axis_tdata,   // r_x, r_y, r_z, scalar
    output logic [1:0]    o_m_axis_tuser    // zero_length, saturated
);

    localparam int CW = vau_pkg::CW;
    localparam int SW = vau_pkg::SW;
    localparam int QW = vau_pkg::QW;

    logic                       w_en;
    logic [2:0][CW-1:0]         w_a;
    logic [2:0][CW-1:0]         w_b;
    logic                       w_mul_v;
    vau_pkg::t_mid              w_mul_mid;
    logic                       w_sq_v;
    vau_pkg::t_mid              w_sq_mid;
    logic [vau_pkg::RW-1:0]     w_root;
    logic                       w_dv_v;
    vau_pkg::t_dv               w_dv;

    logic [2:0][CW-1:0]         n_r;
    logic [SW-1:0]              n_scalar;
    logic                       n_zl;
    logic                       n_sat;
    logic [2:0][CW-1:0]         r_r;
    logic [SW-1:0]              r_scalar;
    logic                       r_zl;
    logic                       r_sat;
    logic                       r_out_v;

    // whole pipeline advances when the output register can move
    assign w_en            = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_a = i_s_axis_tdata[3*CW-1:0];
    assign w_b = i_s_axis_tdata[6*CW-1:3*CW];

    vau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_cmd   (vau_pkg::t_cmd'(i_s_axis_tuser)),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_valid (w_mul_v),
        .o_mid   (w_mul_mid)
    );

    vau_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mul_v),
        .i_mid   (w_mul_mid),
        .o_valid (w_sq_v),
        .o_mid   (w_sq_mid),
        .o_root  (w_root)
    );

    vau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_mid   (w_sq_mid),
        .i_root  (w_root),
        .o_valid (w_dv_v),
        .o_dv    (w_dv)
    );

    // final selection by operation
    always_comb begin
        logic [QW-1:0] q;
        n_r      = w_dv.mid.r;
        n_scalar = w_dv.mid.scalar;
        n_zl     = 1'b0;
        n_sat    = w_dv.mid.sat;
        case (w_dv.mid.cmd)
            vau_pkg::CMD_LEN: begin
                n_scalar = SW'(w_dv.root);
            end
            vau_pkg::CMD_NORM: begin
                if (w_dv.root == '0) begin
                    // only the zero vector has zero length
                    n_r  = '0;
                    n_zl = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        q      = w_dv.q[i];
                        n_r[i] = w_dv.mid.neg[i] ? (CW'(0) - CW'(q)) : CW'(q);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r      <= n_r;
            r_scalar <= n_scalar;
            r_zl     <= n_zl;
            r_sat    <= n_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_scalar, r_r};
    assign o_m_axis_tuser  = {r_sat, r_zl};

`ifndef SYNTHESIS
    // zero length and saturation come from different operations
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("zero_length and saturated both set");

    // a zero-length normalize returns an all-zero item
    a_zero_len_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("zero_length item carries data");

    // a stalled output keeps the pipeline from taking items
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while output stalled");
`endif

endmodule

// ===== sv/vau_mul.sv =====
// products, cross and dot results and the sum of squares (two stages)
module vau_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  vau_pkg::t_cmd                 i_cmd,
    input  logic [2:0][vau_pkg::CW-1:0]   i_a,
    input  logic [2:0][vau_pkg::CW-1:0]   i_b,
    output logic                          o_valid,
    output vau_pkg::t_mid                 o_mid
);

    localparam int CW = vau_pkg::CW;
    localparam int PW = vau_pkg::PW;
    localparam logic signed [PW:0] CLAMP_HI = (PW + 1)'(2 ** (CW - 1) - 1);
    localparam logic signed [PW:0] CLAMP_LO = -CLAMP_HI - (PW + 1)'(1);

    logic signed [PW-1:0]    n_px [6];
    logic signed [PW-1:0]    n_pd [3];
    logic [PW-1:0]           n_sq [3];
    logic [2:0][CW-1:0]      n_mag;
    logic [2:0]              n_neg;

    logic signed [PW-1:0]    r_px [6];
    logic signed [PW-1:0]    r_pd [3];
    logic [PW-1:0]           r_sq [3];
    logic [2:0][CW-1:0]      r_mag;
    logic [2:0]              r_neg;
    vau_pkg::t_cmd           r_cmd;
    logic                    r_v1;

    vau_pkg::t_mid           n_mid;
    vau_pkg::t_mid           r_mid;
    logic                    r_v2;

    // stage one: all products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_px[2*i]   = signed'(i_a[(i+1)%3]) * signed'(i_b[(i+2)%3]);
            n_px[2*i+1] = signed'(i_a[(i+2)%3]) * signed'(i_b[(i+1)%3]);
            n_pd[i]     = signed'(i_a[i]) * signed'(i_b[i]);
            n_neg[i]    = i_a[i][CW-1];
            n_mag[i]    = n_neg[i] ? (CW'(0) - i_a[i]) : i_a[i];
            n_sq[i]     = PW'(n_mag[i]) * PW'(n_mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= n_px;
            r_pd  <= n_pd;
            r_sq  <= n_sq;
            r_mag <= n_mag;
            r_neg <= n_neg;
            r_cmd <= i_cmd;
        end
    end

    // stage two: differences, clamping, sums
    always_comb begin
        logic signed [PW:0]   d;
        logic signed [PW:0]   sh;
        logic signed [PW+1:0] dsum;
        logic                 sat;
        logic [2:0][CW-1:0]   cr;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d  = {r_px[2*i][PW-1], r_px[2*i]} - {r_px[2*i+1][PW-1], r_px[2*i+1]};
            sh = d >>> vau_pkg::FB;
            if (sh > CLAMP_HI) begin
                cr[i] = CLAMP_HI[CW-1:0];
                sat   = 1'b1;
            end else if (sh < CLAMP_LO) begin
                cr[i] = CLAMP_LO[CW-1:0];
                sat   = 1'b1;
            end else begin
                cr[i] = sh[CW-1:0];
            end
        end
        dsum = (PW + 2)'(r_pd[0]) + (PW + 2)'(r_pd[1]) + (PW + 2)'(r_pd[2]);
        dsum = dsum >>> vau_pkg::FB;

        n_mid        = '0;
        n_mid.cmd    = r_cmd;
        n_mid.mag    = r_mag;
        n_mid.neg    = r_neg;
        n_mid.sumsq  = r_sq[0] + r_sq[1] + r_sq[2];
        case (r_cmd)
            vau_pkg::CMD_CROSS: begin
                n_mid.r   = cr;
                n_mid.sat = sat;
            end
            vau_pkg::CMD_DOT: begin
                n_mid.scalar = dsum[vau_pkg::SW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    assign o_valid = r_v2;
    assign o_mid   = r_mid;

endmodule

// ===== sv/vau_sqrt.sv =====
// pipelined floor square root of the sum of squares, two root bits per stage
module vau_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  vau_pkg::t_mid               i_mid,
    output logic                        o_valid,
    output vau_pkg::t_mid               o_mid,
    output logic [vau_pkg::RW-1:0]      o_root
);

    localparam int NSQ = vau_pkg::NSQ;
    localparam int RW  = vau_pkg::RW;

    vau_pkg::t_sq  w_src [NSQ];
    vau_pkg::t_sq  n_st  [NSQ];
    vau_pkg::t_sq  r_st  [NSQ];
    logic [NSQ-1:0] r_v;

    // stage inputs: the new item or the previous stage
    assign w_src[0].mid    = i_mid;
    assign w_src[0].s.rem  = i_mid.sumsq;
    assign w_src[0].s.root = '0;
    for (genvar s = 1; s < NSQ; s++) begin : g_src
        assign w_src[s] = r_st[s-1];
    end

    // two digits in each stage
    always_comb begin
        for (int s = 0; s < NSQ; s++) begin
            n_st[s]     = w_src[s];
            n_st[s].s   = vau_pkg::sqrt_step(w_src[s].s, RW - 1 - 2 * s);
            n_st[s].s   = vau_pkg::sqrt_step(n_st[s].s, RW - 2 - 2 * s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSQ-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_v[NSQ-1];
    assign o_mid   = r_st[NSQ-1].mid;
    assign o_root  = r_st[NSQ-1].s.root;

endmodule

// ===== sv/vau_div.sv =====
// pipelined restoring divider, three lanes, two quotient bits per stage
module vau_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  vau_pkg::t_mid                       i_mid,
    input  logic [vau_pkg::RW-1:0]              i_root,
    output logic                                o_valid,
    output vau_pkg::t_dv                        o_dv
);

    localparam int NDV = vau_pkg::NDV;
    localparam int QW  = vau_pkg::QW;
    localparam int DVW = vau_pkg::DVW;

    vau_pkg::t_dv   w_src [NDV];
    vau_pkg::t_dv   n_st  [NDV];
    vau_pkg::t_dv   r_st  [NDV];
    logic [NDV-1:0] r_v;

    // first stage takes magnitude scaled by the fraction as numerator
    always_comb begin
        w_src[0].mid  = i_mid;
        w_src[0].root = i_root;
        w_src[0].q    = '0;
        for (int i = 0; i < 3; i++) begin
            w_src[0].rem[i] = DVW'(i_mid.mag[i]) << vau_pkg::FB;
        end
    end
    for (genvar s = 1; s < NDV; s++) begin : g_src
        assign w_src[s] = r_st[s-1];
    end

    // each lane does two quotient bits per stage
    always_comb begin
        for (int s = 0; s < NDV; s++) begin
            n_st[s] = w_src[s];
            for (int i = 0; i < 3; i++) begin
                {n_st[s].rem[i], n_st[s].q[i]} = vau_pkg::div_step(
                    w_src[s].rem[i], w_src[s].q[i], w_src[s].root, QW - 1 - 2 * s);
                {n_st[s].rem[i], n_st[s].q[i]} = vau_pkg::div_step(
                    n_st[s].rem[i], n_st[s].q[i], w_src[s].root, QW - 2 - 2 * s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NDV-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_v[NDV-1];
    assign o_dv    = r_st[NDV-1];

endmodule

// ===== verif/vector3_arith_unit_checker.sv =====
// result checker for the vector unit: predicts each item and compares the outputs
module vector3_arith_unit_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    input  logic          i_s_axis_tready,
    input  logic [143:0]  i_s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
    input  logic [1:0]    i_s_axis_tuser,   // cmd
    input  logic          i_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    input  logic [111:0]  i_m_axis_tdata,   // r_x, r_y, r_z, scalar
    input  logic [1:0]    i_m_axis_tuser,   // zero_length, saturated
    output int            o_errors,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = vau_pkg::CW;
    localparam int SW = vau_pkg::SW;
    localparam int FB = vau_pkg::FB;

    typedef struct {
        logic [CW-1:0] rx, ry, rz;
        logic [SW-1:0] scalar;
        logic          zero_len;
        logic          sat;
    } t_vec_result;

    t_vec_result expected_results[$];

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // clamp to a signed width, reporting whether it hit
    function automatic longint clamp_signed(input longint v, input int w, inout logic hit);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // expected result of one vector operation
    function automatic t_vec_result vector_op_predict(input vau_pkg::t_cmd cmd,
                                                      input logic [143:0] d);
        longint a[3], b[3], r[3], sc, dd, mg;
        longint unsigned sumsq, len;
        logic sat, dummy, zl;
        t_vec_result res;
        sat = 0; dummy = 0; zl = 0; sc = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'($signed(d[i*CW +: CW]));
            b[i] = longint'($signed(d[(i+3)*CW +: CW]));
            r[i] = 0;
        end
        sumsq = 0;
        for (int i = 0; i < 3; i++) sumsq += longint'(a[i] * a[i]);
        case (cmd)
            vau_pkg::CMD_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    dd   = a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3];
                    r[i] = clamp_signed(dd >>> FB, CW, sat);
                end
            end
            vau_pkg::CMD_DOT: begin
                dd = 0;
                for (int i = 0; i < 3; i++) dd += a[i] * b[i];
                sc = clamp_signed(dd >>> FB, SW, dummy);
            end
            vau_pkg::CMD_LEN: begin
                sc = longint'(floor_sqrt(sumsq));
            end
            default: begin
                len = floor_sqrt(sumsq);
                if (len == 0) begin
                    for (int i = 0; i < 3; i++) r[i] = a[i];
                    zl = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        mg   = (a[i] < 0) ? -a[i] : a[i];
                        mg   = longint'((unsigned'(mg) << FB) / len);
                        r[i] = clamp_signed((a[i] < 0) ? -mg : mg, CW, dummy);
                    end
                end
            end
        endcase
        res.rx       = r[0][CW-1:0];
        res.ry       = r[1][CW-1:0];
        res.rz       = r[2][CW-1:0];
        res.scalar   = sc[SW-1:0];
        res.zero_len = zl;
        res.sat      = sat;
        return res;
    endfunction

    assign o_pending = expected_results.size();

    // compare outputs, then record new items
    always @(posedge i_clk) begin
        t_vec_result exp_r;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                             i_m_axis_tdata, i_m_axis_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.rx !== i_m_axis_tdata[23:0] ||
                        exp_r.ry !== i_m_axis_tdata[47:24] ||
                        exp_r.rz !== i_m_axis_tdata[71:48] ||
                        exp_r.scalar !== i_m_axis_tdata[111:72] ||
                        exp_r.zero_len !== i_m_axis_tuser[0] ||
                        exp_r.sat !== i_m_axis_tuser[1]) begin
                        $display("%0t: mismatch expected r=%h %h %h s=%h zl=%b sat=%b",
                                 $time, exp_r.rx, exp_r.ry, exp_r.rz, exp_r.scalar,
                                 exp_r.zero_len, exp_r.sat);
                        $display("%0t:          actual   r=%h %h %h s=%h zl=%b sat=%b",
                                 $time, i_m_axis_tdata[23:0], i_m_axis_tdata[47:24],
                                 i_m_axis_tdata[71:48], i_m_axis_tdata[111:72],
                                 i_m_axis_tuser[0], i_m_axis_tuser[1]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_results.push_back(
                    vector_op_predict(vau_pkg::t_cmd'(i_s_axis_tuser), i_s_axis_tdata));
        end
    end
endmodule

// ===== verif/vector3_arith_unit_test.sv =====
// testbench top for the vector unit: stimulus, flow control and verdict
module vector3_arith_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [143:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [111:0]  m_tdata;
    logic [1:0]    m_tuser;
    int            errors, pending;
    int            tx_idle_pct = 0, rx_stall_pct = 0;
    bit            hold_request = 0;
    int            quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    vector3_arith_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    vector3_arith_unit_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_request = 0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // offer one item, holding valid high until taken
    task automatic send_vector_op(input vau_pkg::t_cmd cmd, input logic [23:0] a[3],
                                  input logic [23:0] b[3]);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {b[2], b[1], b[0], a[2], a[1], a[0]};
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [23:0] random_component();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 24'($urandom);
            5, 6, 7: return ($urandom_range(0, 1) ? 24'($urandom_range(0, 2000))
                                                  : -24'($urandom_range(0, 2000)));
            8: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default: return 24'd0;
        endcase
    endfunction

    task automatic send_random_batch(input int count);
        logic [23:0] a[3], b[3];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = random_component();
                b[i] = random_component();
            end
            if ($urandom_range(0, 19) == 0) a = '{24'd0, 24'd0, 24'd0};
            send_vector_op(vau_pkg::t_cmd'($urandom_range(0, 3)), a, b);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    // directed extremes for every operation
    task automatic send_directed();
        logic [23:0] mx[3], mn[3], zr[3], one[3], mixed[3];
        vau_pkg::t_cmd ops[4];
        mx = '{24'h7fffff, 24'h7fffff, 24'h7fffff};
        mn = '{24'h800000, 24'h800000, 24'h800000};
        zr = '{24'd0, 24'd0, 24'd0};
        one = '{24'd1, 24'd0, 24'd0};
        mixed = '{24'h7fffff, 24'h800000, 24'h010000};
        ops = '{vau_pkg::CMD_CROSS, vau_pkg::CMD_DOT, vau_pkg::CMD_LEN, vau_pkg::CMD_NORM};
        foreach (ops[k]) begin
            send_vector_op(ops[k], mx, mn);
            send_vector_op(ops[k], mn, mn);
            send_vector_op(ops[k], zr, mx);
            send_vector_op(ops[k], one, mixed);
            send_vector_op(ops[k], mixed, '{24'h800000, 24'h7fffff, 24'hff0000});
        end
        // cross overflow on the negative side and a single-lsb normalize
        send_vector_op(vau_pkg::CMD_CROSS, '{24'h7fffff, 24'h800000, 24'd0},
                       '{24'h800000, 24'h800000, 24'd0});
        send_vector_op(vau_pkg::CMD_NORM, '{24'd0, 24'hffffff, 24'd0}, zr);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        drain();
        // no idling
        tx_idle_pct = 0; rx_stall_pct = 0;
        send_random_batch(400);
        // sender idle
        tx_idle_pct = 83; rx_stall_pct = 0;
        send_random_batch(400);
        // receiver stalling, with one long hold-off while items keep coming
        tx_idle_pct = 0; rx_stall_pct = 83;
        hold_request = 1;
        send_random_batch(400);
        // sender pauses until everything is back
        drain();
        tx_idle_pct = 6; rx_stall_pct = 6;
        send_random_batch(400);
        tx_idle_pct = 0; rx_stall_pct = 0;
        send_random_batch(400);
        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
